@@ sv/ptss_pkg.sv @@
// Shared types and codes for the task-slot scheduler.
// No dependencies.
package ptss_pkg;
    localparam logic [2:0] OP_POST    = 3'd0;
    localparam logic [2:0] OP_POST_D  = 3'd1;
    localparam logic [2:0] OP_CANCEL  = 3'd2;
    localparam logic [2:0] OP_ACTIVE  = 3'd3;
    localparam logic [2:0] OP_BEGIN   = 3'd4;
    localparam logic [2:0] OP_REPORT  = 3'd5;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    localparam logic [1:0] EV_PLAIN    = 2'd0;
    localparam logic [1:0] EV_DISPATCH = 2'd1;
    localparam logic [1:0] EV_PASS     = 2'd2;

    localparam logic [1:0] PRIO_LOW = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  priority_req;
        logic [31:0] now_time;
        logic [31:0] delay;
        logic [15:0] prereq_id;
        logic [15:0] target_id;
        logic        complete;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        ok;
        logic [15:0] task_id;
        logic [4:0]  executed;
        logic [4:0]  occupied;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the input beat
        logic post;      // write the found empty slot
        logic cancel;    // free the found slot
        logic begin_pass;
        logic report;    // close the running task
        logic find_clr;  // restart the linear search
        logic find_step; // advance the linear search
        logic dep_clr;   // restart the dependency search
        logic dep_step;
        logic scan_step; // advance the scan pointer
        logic dispatch;  // mark the scan slot running
        logic pass_end;
        logic set_res;   // register the result
        logic fix;       // latch the settled occupied count into the beat
        logic [1:0] res_event;
        logic       res_ok;
        logic       res_id_sel; // 1: dispatched id, 0: new post id
        logic       res_id_zero;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       find_done;
        logic       find_hit;
        logic       tgt_zero;
        logic       hit_running;
        logic       pass_busy;
        logic       run_ok;
        logic       scan_done;
        logic       cand;      // scan slot pending, right priority, time ok
        logic       dep_none;
        logic       dep_done;
        logic       dep_hit;
    } t_sts;
endpackage

@@ sv/ptss_if.sv @@
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type is a parameter.
interface ptss_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/ptss_dp.sv @@
// Datapath: slot table, id counter, search and scan pointers, result register.
// Depends on ptss_pkg.
module ptss_dp #(
    parameter int SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptss_pkg::t_in  i_in,
    input  ptss_pkg::t_cmd i_cmd,
    output ptss_pkg::t_sts o_sts,
    output ptss_pkg::t_out o_res,
    output logic [$clog2(SLOTS+1)-1:0] o_occ
);
    import ptss_pkg::*;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [1:0]  r_status [SLOTS];
    logic [15:0] r_id     [SLOTS];
    logic [31:0] r_rel    [SLOTS];
    logic [15:0] r_dep    [SLOTS];
    logic [1:0]  r_prio   [SLOTS];

    t_in         r_in;
    logic [15:0] r_idc;
    logic [1:0]  r_sprio;
    logic [CW-1:0] r_sslot;
    logic [31:0] r_ptime;
    logic        r_busy;
    logic [IW-1:0] r_run;
    logic [4:0]  r_cnt;
    logic [CW-1:0] r_find;
    logic [CW-1:0] r_dptr;
    logic [CW-1:0] r_occ;
    t_out        r_res;

    logic [IW-1:0] fidx, sidx, didx;
    logic        f_match;
    logic [15:0] n_idc;
    logic [15:0] dep_id;

    assign fidx = r_find[IW-1:0];
    assign sidx = r_sslot[IW-1:0];
    assign didx = r_dptr[IW-1:0];
    assign dep_id = r_dep[sidx];

    always_comb begin
        if (r_in.operation == OP_POST || r_in.operation == OP_POST_D)
            f_match = (r_status[fidx] == ST_EMPTY);
        else
            f_match = (r_status[fidx] != ST_EMPTY) && (r_id[fidx] == r_in.target_id);
        n_idc = r_idc + 16'd1;
        if (n_idc == 16'd0) n_idc = 16'd1;
    end

    always_comb begin
        o_sts.op          = r_in.operation;
        o_sts.find_done   = (r_find == CW'(SLOTS));
        o_sts.find_hit    = (r_find != CW'(SLOTS)) && f_match;
        o_sts.tgt_zero    = (r_in.target_id == 16'd0);
        o_sts.hit_running = (r_status[fidx] == ST_RUNNING);
        o_sts.pass_busy   = r_busy;
        o_sts.run_ok      = r_busy && (r_status[r_run] == ST_RUNNING);
        o_sts.scan_done   = (r_sprio == PRIO_LOW) && (r_sslot == CW'(SLOTS));
        o_sts.cand        = (r_sslot != CW'(SLOTS)) && (r_status[sidx] == ST_PENDING)
                            && (r_prio[sidx] == r_sprio)
                            && !(r_rel[sidx] != 32'd0 && r_ptime < r_rel[sidx]);
        o_sts.dep_none    = (dep_id == 16'd0);
        o_sts.dep_done    = (r_dptr == CW'(SLOTS));
        o_sts.dep_hit     = (r_dptr != CW'(SLOTS)) && (r_status[didx] != ST_EMPTY)
                            && (r_id[didx] == dep_id);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_status[k] <= ST_EMPTY;
                r_id[k]     <= 16'd0;
            end
            r_idc   <= 16'd1;
            r_sprio <= 2'd0;
            r_sslot <= '0;
            r_ptime <= 32'd0;
            r_busy  <= 1'b0;
            r_run   <= '0;
            r_cnt   <= 5'd0;
            r_find  <= '0;
            r_dptr  <= '0;
            r_occ   <= '0;
        end else begin
            if (i_cmd.find_clr) r_find <= '0;
            else if (i_cmd.find_step) r_find <= r_find + CW'(1);
            if (i_cmd.dep_clr) r_dptr <= '0;
            else if (i_cmd.dep_step) r_dptr <= r_dptr + CW'(1);
            if (i_cmd.post) begin
                r_status[fidx] <= ST_PENDING;
                r_id[fidx]     <= r_idc;
                r_rel[fidx]    <= (r_in.operation == OP_POST_D) ?
                                  r_in.now_time + r_in.delay : 32'd0;
                r_dep[fidx]    <= r_in.prereq_id;
                r_prio[fidx]   <= (r_in.priority_req == 2'd3) ? PRIO_LOW : r_in.priority_req;
                r_idc          <= n_idc;
                r_occ          <= r_occ + CW'(1);
            end
            if (i_cmd.cancel) begin
                r_status[fidx] <= ST_EMPTY;
                r_id[fidx]     <= 16'd0;
                r_occ          <= r_occ - CW'(1);
            end
            if (i_cmd.begin_pass) begin
                r_ptime <= r_in.now_time;
                r_sprio <= 2'd0;
                r_sslot <= '0;
                r_cnt   <= 5'd0;
            end
            if (i_cmd.report) begin
                r_busy <= 1'b0;
                if (r_in.complete) begin
                    r_status[r_run] <= ST_EMPTY;
                    r_id[r_run]     <= 16'd0;
                    r_occ           <= r_occ - CW'(1);
                end else begin
                    r_status[r_run] <= ST_PENDING;
                end
            end
            if (i_cmd.scan_step) begin
                // wrap to the next priority after the last slot
                if (r_sslot == CW'(SLOTS)) begin
                    r_sprio <= r_sprio + 2'd1;
                    r_sslot <= '0;
                end else begin
                    r_sslot <= r_sslot + CW'(1);
                end
            end
            if (i_cmd.dispatch) begin
                r_status[sidx] <= ST_RUNNING;
                r_run   <= sidx;
                r_busy  <= 1'b1;
                r_sslot <= r_sslot + CW'(1);
                if (r_cnt != 5'd31) r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.pass_end) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.set_res) begin
            r_res.event_res <= i_cmd.res_event;
            r_res.ok        <= i_cmd.res_ok;
            if (i_cmd.res_id_zero) r_res.task_id <= 16'd0;
            else if (i_cmd.res_id_sel) r_res.task_id <= r_id[sidx];
            else r_res.task_id <= r_idc;
            r_res.executed  <= (i_cmd.dispatch && r_cnt != 5'd31) ? r_cnt + 5'd1 : r_cnt;
            r_res.occupied  <= (CW > 5 && r_occ > CW'(31)) ? 5'd31 : 5'(r_occ);
        end
    end

    // occupied here is provisional; the output stage latches the settled count
    assign o_res = r_res;
    assign o_occ = r_occ;
endmodule

@@ sv/ptss_ctrl.sv @@
// Controller: sequences search, post, cancel, report and the dispatch scan.
// Depends on ptss_pkg.
module ptss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ptss_pkg::t_sts i_sts,
    output ptss_pkg::t_cmd o_cmd
);
    import ptss_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEP  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4; // let the occupied count settle
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_ok, n_ok;

    assign o_in_ready  = (r_state == S_IDLE) && !o_out_valid;
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ok    = r_ok;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.find_clr = 1'b1;
                    n_state        = S_FIND;
                end
            end
            S_FIND: begin
                unique case (i_sts.op)
                    OP_POST, OP_POST_D: begin
                        if (i_sts.find_hit) begin
                            o_cmd.post    = 1'b1;
                            o_cmd.set_res = 1'b1;
                            o_cmd.res_ok  = 1'b1;
                            n_state       = S_FIX;
                        end else if (i_sts.find_done) begin
                            o_cmd.set_res     = 1'b1;
                            o_cmd.res_id_zero = 1'b1;
                            n_state           = S_FIX;
                        end else o_cmd.find_step = 1'b1;
                    end
                    OP_CANCEL, OP_ACTIVE: begin
                        o_cmd.res_id_zero = 1'b1;
                        if (i_sts.tgt_zero || i_sts.find_done) begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_FIX;
                        end else if (i_sts.find_hit) begin
                            o_cmd.set_res = 1'b1;
                            if (i_sts.op == OP_ACTIVE) o_cmd.res_ok = 1'b1;
                            else if (!i_sts.hit_running) begin
                                o_cmd.res_ok = 1'b1;
                                o_cmd.cancel = 1'b1;
                            end
                            n_state = S_FIX;
                        end else o_cmd.find_step = 1'b1;
                    end
                    OP_BEGIN: begin
                        o_cmd.res_id_zero = 1'b1;
                        if (i_sts.pass_busy) begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_FIX;
                        end else begin
                            o_cmd.begin_pass = 1'b1;
                            n_ok    = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    OP_REPORT: begin
                        o_cmd.res_id_zero = 1'b1;
                        if (i_sts.run_ok) begin
                            o_cmd.report = 1'b1;
                            n_ok    = 1'b1;
                            n_state = S_SCAN;
                        end else begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_FIX;
                        end
                    end
                    default: begin
                        o_cmd.res_id_zero = 1'b1;
                        o_cmd.set_res     = 1'b1;
                        n_state           = S_FIX;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.dep_clr = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.pass_end    = 1'b1;
                    o_cmd.set_res     = 1'b1;
                    o_cmd.res_event   = EV_PASS;
                    o_cmd.res_ok      = r_ok;
                    o_cmd.res_id_zero = 1'b1;
                    n_state           = S_FIX;
                end else if (i_sts.cand && i_sts.dep_none) begin
                    o_cmd.dispatch   = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_event  = EV_DISPATCH;
                    o_cmd.res_ok     = r_ok;
                    o_cmd.res_id_sel = 1'b1;
                    n_state          = S_FIX;
                end else if (i_sts.cand) begin
                    n_state = S_DEP;
                end else o_cmd.scan_step = 1'b1;
            end
            S_DEP: begin
                if (i_sts.dep_hit) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_sts.dep_done) begin
                    o_cmd.dispatch   = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_event  = EV_DISPATCH;
                    o_cmd.res_ok     = r_ok;
                    o_cmd.res_id_sel = 1'b1;
                    n_state          = S_FIX;
                end else o_cmd.dep_step = 1'b1;
            end
            S_FIX: begin
                // refresh the beat with the settled occupied count
                o_cmd.fix = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
    end
endmodule

@@ sv/ptss_occ.sv @@
// Output stage: merges the result beat with the settled occupied count.
// Depends on ptss_pkg.
module ptss_occ #(
    parameter int SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_fix,
    input  ptss_pkg::t_out i_res,
    input  logic [$clog2(SLOTS+1)-1:0] i_occ,
    output ptss_pkg::t_out o_res
);
    import ptss_pkg::*;
    localparam int CW = $clog2(SLOTS + 1);
    t_out r_res, n_res;
    always_comb begin
        n_res = i_res;
        n_res.occupied = (CW > 5 && 32'(i_occ) > 32'd31) ? 5'd31 : 5'(i_occ);
    end
    always_ff @(posedge i_clk) begin
        if (i_fix) r_res <= n_res;
    end
    assign o_res = r_res;
endmodule

@@ sv/priority_task_slot_scheduler.sv @@
// Top level of the task-slot scheduler.
// Depends on ptss_pkg, ptss_if, ptss_dp, ptss_ctrl and ptss_occ.
//
// Usage: one request beat on the input channel gives exactly one reply beat
// on the output channel. Posts and id lookups search the slot table one slot
// a cycle. Begin and report walk the scan pointer one slot a cycle over three
// priorities, except while a candidate's dependency is searched; each
// candidate whose dependency is set checks the table one slot a cycle. One
// request is in flight at a time, and the next request is taken in the
// cycle after the reply leaves.
// Reset (synchronous, active low) empties every slot, sets the id counter to
// 1 and clears the pass state; the block takes a beat in the next cycle.
// A stalled receiver holds the reply beat in the output register, and no new
// request is taken until it leaves.
module priority_task_slot_scheduler #(
    parameter int SLOTS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    ptss_if.sink   i_req,
    ptss_if.source o_rsp
);
    import ptss_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_out dp_res;
    t_out res;
    logic [$clog2(SLOTS+1)-1:0] occ;
    logic in_ready, out_valid;

    ptss_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptss_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk, .i_rst_n,
        .i_in  (i_req.data),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_res (dp_res),
        .o_occ (occ)
    );

    ptss_occ #(.SLOTS(SLOTS)) u_occ (
        .i_clk,
        .i_fix (cmd.fix),
        .i_res (dp_res),
        .i_occ (occ),
        .o_res (res)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = res;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("ready while reply pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_rsp.ready |=> out_valid && $stable(res))
        else $error("reply beat dropped under stall");
    a_disp_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && res.event_res == EV_DISPATCH |-> res.task_id != 16'd0)
        else $error("dispatched id zero");
endmodule
